>>> src/cbii_pkg.sv
`default_nettype none

package cbii_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_LINE_DEFAULT    = 1024;
	localparam int WEIGHT_BITS_DEFAULT = 16;
	localparam int SUM_BITS_DEFAULT    = 48;

	// Fixed field widths of the request and result items.
	localparam int CHAN_BITS       = 8;
	localparam int BIN_BITS        = 9;
	localparam int TABLE_DEPTH     = 512;
	localparam int TABLE_VAL_BITS  = 16;
	localparam int OUT_BITS        = 48;
	localparam int MASK_BITS       = 8;
	localparam int LINE_WIDTH_BITS = 11;

	// Each channel keeps its top three bits.
	localparam int CHAN_SHIFT = 5;

	localparam logic [LINE_WIDTH_BITS-1:0] LINE_WIDTH_RESET = 11'd640;
	localparam logic [MASK_BITS-1:0]       MASK_ON          = 8'd255;
	localparam logic [MASK_BITS-1:0]       MASK_OFF         = 8'd0;

	// Request kinds.
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_TABLE = 1'b1;

	typedef struct packed {
		logic                              func;
		logic                              frame_start;
		logic [CHAN_BITS-1:0]              chan0;
		logic [CHAN_BITS-1:0]              chan1;
		logic [CHAN_BITS-1:0]              chan2;
		logic [BIN_BITS-1:0]               table_index;
		logic signed [TABLE_VAL_BITS-1:0]  table_value;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] integral_value;
		logic [MASK_BITS-1:0]       mask_byte;
	} out_item_t;

	// Row bookkeeping that goes with each pixel into the datapath.
	typedef struct packed {
		logic row_fresh;  // row total starts again from zero at this pixel
		logic first_row;  // no previous row to add for this pixel
	} row_flags_t;

endpackage

`default_nettype wire

>>> src/cbii_weight_lut.sv
`default_nettype none

module cbii_weight_lut #(
	parameter int WEIGHT_BITS = cbii_pkg::WEIGHT_BITS_DEFAULT
) (
	input  wire logic                                     clk,
	input  wire logic                                     wr_en,
	input  wire logic [cbii_pkg::BIN_BITS-1:0]            wr_addr,
	input  wire logic signed [cbii_pkg::TABLE_VAL_BITS-1:0] wr_value,
	input  wire logic                                     rd_en,
	input  wire logic [cbii_pkg::BIN_BITS-1:0]            rd_addr,
	output logic [WEIGHT_BITS-1:0]                        rd_data
);
	import cbii_pkg::*;

	localparam logic signed [32:0] W_MAX = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
	localparam logic signed [32:0] W_MIN = -W_MAX - 33'sd1;

	logic [WEIGHT_BITS-1:0] mem [TABLE_DEPTH];
	logic signed [32:0]     wr_wide;
	logic [WEIGHT_BITS-1:0] wr_clamped;

	// Stored weights saturate to the table word width.
	always_comb begin
		wr_wide = 33'(wr_value);
		if (wr_wide > W_MAX) begin
			wr_clamped = WEIGHT_BITS'(W_MAX);
		end else if (wr_wide < W_MIN) begin
			wr_clamped = WEIGHT_BITS'(W_MIN);
		end else begin
			wr_clamped = WEIGHT_BITS'(wr_wide);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_clamped;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/cbii_line_store.sv
`default_nettype none

module cbii_line_store #(
	parameter int MAX_LINE = cbii_pkg::MAX_LINE_DEFAULT,
	parameter int SUM_BITS = cbii_pkg::SUM_BITS_DEFAULT
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [$clog2(MAX_LINE)-1:0] wr_addr,
	input  wire logic [SUM_BITS-1:0]         wr_data,
	input  wire logic                        rd_en,
	input  wire logic [$clog2(MAX_LINE)-1:0] rd_addr,
	output logic [SUM_BITS-1:0]              rd_data
);
	logic [SUM_BITS-1:0] mem [MAX_LINE];

	// A read at the address being written returns the old word; the
	// datapath forwards recent writes itself.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> src/cbii_raster_ctrl.sv
`default_nettype none

module cbii_raster_ctrl #(
	parameter int MAX_LINE = cbii_pkg::MAX_LINE_DEFAULT
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  pixel_take,
	input  wire logic                                  frame_start,
	input  wire logic [cbii_pkg::LINE_WIDTH_BITS-1:0]  line_width,
	output logic [$clog2(MAX_LINE)-1:0]                col,
	output cbii_pkg::row_flags_t                       flags
);
	import cbii_pkg::*;

	localparam int CW = $clog2(MAX_LINE);
	localparam int EW = (CW + 1 > LINE_WIDTH_BITS) ? CW + 1 : LINE_WIDTH_BITS;
	localparam logic [EW-1:0] MAX_EXT = EW'(MAX_LINE);
	localparam logic [EW-1:0] ONE_EXT = EW'(1);

	logic [CW-1:0] col_q;
	logic          fresh_q;
	logic          first_q;
	logic [EW-1:0] width_ext;
	logic [EW-1:0] width_eff;
	logic [EW-1:0] col_next;
	logic          row_end;

	always_comb begin
		width_ext = EW'(line_width);
		if (width_ext == '0) begin
			width_eff = ONE_EXT;
		end else if (width_ext > MAX_EXT) begin
			width_eff = MAX_EXT;
		end else begin
			width_eff = width_ext;
		end
		col             = frame_start ? '0 : col_q;
		flags.row_fresh = frame_start | fresh_q;
		flags.first_row = frame_start | first_q;
		col_next        = EW'(col) + ONE_EXT;
		// A narrowed width in mid-row ends the row at once.
		row_end         = col_next >= width_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			fresh_q <= 1'b1;
			first_q <= 1'b1;
		end else if (pixel_take) begin
			col_q   <= row_end ? '0 : col_next[CW-1:0];
			fresh_q <= row_end;
			first_q <= row_end ? 1'b0 : flags.first_row;
		end
	end

endmodule

`default_nettype wire

>>> src/color_backproject_integral_image.sv
`default_nettype none

// Color histogram back-projection with a running integral image. Each pixel
// request carries three 8-bit channels; their top three bits form a 9-bit bin
// that selects a signed Q8.8 weight from a 512-word table loaded by table
// write requests. The block returns, per pixel, the saturating sum of weights
// over the rectangle from the frame origin to that pixel, plus a mask byte of
// 255 where the weight is positive. A table write gives no result. The core
// takes one request every clock while the result register is free or being
// emptied. A result passes the synchronous read of the weight table and the
// line store, then the row-total add and the previous-row add in separate
// stages. Throughput stalls only when the result is held by the downstream
// stall. The line store has no reset and no clearing pass: the first row of
// every frame never uses what it reads, and each later entry is read only
// after the row before has written it. line_width may only be changed while
// the block is idle; zero acts as one and values above MAX_LINE act as
// MAX_LINE. Table words must be written before pixels that use them arrive.

module color_backproject_integral_image #(
	parameter int MAX_LINE    = cbii_pkg::MAX_LINE_DEFAULT,
	parameter int WEIGHT_BITS = cbii_pkg::WEIGHT_BITS_DEFAULT,
	parameter int SUM_BITS    = cbii_pkg::SUM_BITS_DEFAULT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire cbii_pkg::in_item_t                   in_item,
	output logic                                      res_valid,
	input  wire logic                                 res_stall,
	output cbii_pkg::out_item_t                       res_item,
	input  wire logic                                 cfg_we,
	input  wire logic [cbii_pkg::LINE_WIDTH_BITS-1:0] cfg_wdata
);
	import cbii_pkg::*;

	localparam int CW = $clog2(MAX_LINE);
	localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

	function automatic logic signed [SUM_BITS-1:0] sat_add(
		input logic signed [SUM_BITS-1:0] a,
		input logic signed [SUM_BITS-1:0] b
	);
		logic signed [SUM_BITS:0] s;
		logic signed [SUM_BITS-1:0] r;
		s = (SUM_BITS+1)'(a) + (SUM_BITS+1)'(b);
		if (s[SUM_BITS] != s[SUM_BITS-1]) begin
			r = s[SUM_BITS] ? SUM_MIN : SUM_MAX;
		end else begin
			r = s[SUM_BITS-1:0];
		end
		return r;
	endfunction

	// The whole pipeline moves together whenever the result register is free
	// or being emptied this cycle.
	logic adv;
	logic take;
	logic pixel_take;
	logic table_take;

	assign adv        = !res_valid || !res_stall;
	assign in_stall   = !adv;
	assign take       = in_valid && adv;
	assign pixel_take = take && (in_item.func == FUNC_PIXEL);
	assign table_take = take && (in_item.func == FUNC_TABLE);

	// Line width register.
	logic [LINE_WIDTH_BITS-1:0] line_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (cfg_we) begin
			line_width_q <= cfg_wdata;
		end
	end

	// Raster position of the incoming pixel.
	logic [CW-1:0] col_s0;
	row_flags_t    flags_s0;

	cbii_raster_ctrl #(
		.MAX_LINE (MAX_LINE)
	) u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_take  (pixel_take),
		.frame_start (in_item.frame_start),
		.line_width  (line_width_q),
		.col         (col_s0),
		.flags       (flags_s0)
	);

	// Weight table; the read is issued as the pixel is taken.
	logic [BIN_BITS-1:0]    bin_s0;
	logic [WEIGHT_BITS-1:0] weight_rd;

	assign bin_s0 = {in_item.chan0[CHAN_BITS-1:CHAN_SHIFT],
			in_item.chan1[CHAN_BITS-1:CHAN_SHIFT],
			in_item.chan2[CHAN_BITS-1:CHAN_SHIFT]};

	cbii_weight_lut #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_lut (
		.clk      (clk),
		.wr_en    (table_take),
		.wr_addr  (in_item.table_index),
		.wr_value (in_item.table_value),
		.rd_en    (pixel_take),
		.rd_addr  (bin_s0),
		.rd_data  (weight_rd)
	);

	// Line store of the previous row's integral values.
	logic                wr_en_s2;
	logic [CW-1:0]       col_s2;
	logic [SUM_BITS-1:0] prior_rd;
	logic signed [SUM_BITS-1:0] result_s2;

	cbii_line_store #(
		.MAX_LINE (MAX_LINE),
		.SUM_BITS (SUM_BITS)
	) u_line (
		.clk     (clk),
		.wr_en   (wr_en_s2),
		.wr_addr (col_s2),
		.wr_data (result_s2),
		.rd_en   (pixel_take),
		.rd_addr (col_s0),
		.rd_data (prior_rd)
	);

	// Stage 1: weight and prior word arrive; the row total is updated.
	logic                       v_s1;
	logic [CW-1:0]              col_s1;
	row_flags_t                 flags_s1;
	logic signed [WEIGHT_BITS-1:0] weight_s1;
	logic signed [SUM_BITS-1:0] weight_ext_s1;
	logic signed [SUM_BITS-1:0] rt_q;
	logic signed [SUM_BITS-1:0] rt_new_s1;

	always_comb begin
		weight_s1     = weight_rd;
		weight_ext_s1 = SUM_BITS'(weight_s1);
		rt_new_s1     = sat_add(flags_s1.row_fresh ? '0 : rt_q, weight_ext_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			rt_q <= '0;
		end else if (adv) begin
			v_s1 <= pixel_take;
			if (v_s1) begin
				rt_q <= rt_new_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pixel_take) begin
			col_s1   <= col_s0;
			flags_s1 <= flags_s0;
		end
	end

	// Stage 2: add the previous row and write the line store back.
	logic                       v_s2;
	logic                       first_s2;
	logic signed [SUM_BITS-1:0] rt_s2;
	logic signed [SUM_BITS-1:0] prior_s2;
	logic [MASK_BITS-1:0]       mask_s2;

	// The last two line-store writes, newest first. They cover every write
	// that landed after the pixel's own read was issued.
	logic                       w1_v_q;
	logic                       w2_v_q;
	logic [CW-1:0]              w1_col_q;
	logic [CW-1:0]              w2_col_q;
	logic signed [SUM_BITS-1:0] w1_val_q;
	logic signed [SUM_BITS-1:0] w2_val_q;
	logic signed [SUM_BITS-1:0] prior_fwd_s2;

	always_comb begin
		if (w1_v_q && (w1_col_q == col_s2)) begin
			prior_fwd_s2 = w1_val_q;
		end else if (w2_v_q && (w2_col_q == col_s2)) begin
			prior_fwd_s2 = w2_val_q;
		end else begin
			prior_fwd_s2 = prior_s2;
		end
		result_s2 = first_s2 ? rt_s2 : sat_add(rt_s2, prior_fwd_s2);
	end

	assign wr_en_s2 = adv && v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			w1_v_q <= 1'b0;
			w2_v_q <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			if (v_s2) begin
				w1_v_q <= 1'b1;
				w2_v_q <= w1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			col_s2   <= col_s1;
			first_s2 <= flags_s1.first_row;
			rt_s2    <= rt_new_s1;
			prior_s2 <= prior_rd;
			mask_s2  <= (weight_s1 > 0) ? MASK_ON : MASK_OFF;
		end
		if (wr_en_s2) begin
			w1_col_q <= col_s2;
			w1_val_q <= result_s2;
			w2_col_q <= w1_col_q;
			w2_val_q <= w1_val_q;
		end
	end

	// Result register.
	logic      res_valid_q;
	out_item_t res_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en_s2) begin
			res_item_q.integral_value <= OUT_BITS'(result_s2);
			res_item_q.mask_byte      <= mask_s2;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// Every line-store write leaves a result behind in the output register.
	a_write_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_s2 |=> res_valid_q)
		else $error("line-store write without a result");

	// A fresh row total equals the pixel's own weight.
	a_fresh_row_total: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && flags_s1.row_fresh) |=> (rt_q == $past(weight_ext_s1)))
		else $error("row total did not restart");

	// The forwarding register tracks the value just sent out.
	a_forward_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_s2 |=> (res_item_q.integral_value == OUT_BITS'(w1_val_q)))
		else $error("forwarded value differs from result");

	// The mask byte only takes its two codes.
	a_mask_codes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_item_q.mask_byte == MASK_ON) ||
			(res_item_q.mask_byte == MASK_OFF)))
		else $error("bad mask byte");

endmodule

`default_nettype wire

>>> test/cbii_integral_checker.sv
module cbii_integral_checker
	import cbii_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_stall,
	input  wire in_item_t                   in_item,
	input  wire logic                       res_valid,
	input  wire logic                       res_stall,
	input  wire out_item_t                  res_item,
	input  wire logic                       cfg_we,
	input  wire logic [LINE_WIDTH_BITS-1:0] cfg_wdata,
	output int                              errors,
	output int                              pending
);

	// Shadow copy of the block state.
	logic signed [TABLE_VAL_BITS-1:0] weights [TABLE_DEPTH];
	logic signed [OUT_BITS-1:0]       line_sums [MAX_LINE_DEFAULT];
	logic signed [OUT_BITS-1:0]       row_total;
	int unsigned                      col_pos;
	bit                               first_row;
	logic [LINE_WIDTH_BITS-1:0]       width_reg;

	out_item_t expected_sums [$];

	// Signed add that clamps at the 48-bit limits instead of wrapping.
	function automatic logic signed [OUT_BITS-1:0] sum_clamped(
		input logic signed [OUT_BITS-1:0] a,
		input logic signed [OUT_BITS-1:0] b
	);
		logic signed [OUT_BITS:0] wide;
		wide = a + b;
		if (wide[OUT_BITS] != wide[OUT_BITS-1])
			return wide[OUT_BITS] ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
		return wide[OUT_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict_integral
		out_item_t                        want;
		logic [BIN_BITS-1:0]              bin;
		logic signed [TABLE_VAL_BITS-1:0] weight;
		int unsigned                      span;
		int                               bad;
		if (!arst_n) begin
			expected_sums.delete();
			row_total = '0;
			col_pos   = 0;
			first_row = 1'b1;
			width_reg = LINE_WIDTH_RESET;
			errors  <= 0;
			pending <= 0;
		end else begin
			bad = 0;
			// Results are checked before new requests are predicted, so a stray
			// result can never match an expectation pushed in the same cycle.
			if (res_valid && !res_stall) begin
				if (expected_sums.size() == 0) begin
					$display("%0t: unexpected result, integral %0d mask %0d",
						$time, res_item.integral_value, res_item.mask_byte);
					bad++;
				end else begin
					want = expected_sums.pop_front();
					if (res_item.integral_value !== want.integral_value) begin
						$display("%0t: integral_value expected %0d actual %0d",
							$time, want.integral_value, res_item.integral_value);
						bad++;
					end
					if (res_item.mask_byte !== want.mask_byte) begin
						$display("%0t: mask_byte expected %0d actual %0d",
							$time, want.mask_byte, res_item.mask_byte);
						bad++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_item.func == FUNC_TABLE) begin
					weights[in_item.table_index] = in_item.table_value;
				end else begin
					if (in_item.frame_start) begin
						col_pos   = 0;
						row_total = '0;
						first_row = 1'b1;
					end
					span = 32'(width_reg);
					if (span < 1)
						span = 1;
					if (span > MAX_LINE_DEFAULT)
						span = MAX_LINE_DEFAULT;
					bin = {in_item.chan0[CHAN_BITS-1:CHAN_SHIFT],
						in_item.chan1[CHAN_BITS-1:CHAN_SHIFT],
						in_item.chan2[CHAN_BITS-1:CHAN_SHIFT]};
					weight = weights[bin];
					row_total = sum_clamped(row_total, OUT_BITS'(weight));
					if (first_row)
						want.integral_value = row_total;
					else
						want.integral_value = sum_clamped(row_total, line_sums[col_pos]);
					line_sums[col_pos] = want.integral_value;
					want.mask_byte = (weight > 0) ? MASK_ON : MASK_OFF;
					expected_sums.push_back(want);
					if (col_pos + 1 >= span) begin
						col_pos   = 0;
						row_total = '0;
						first_row = 1'b0;
					end else begin
						col_pos++;
					end
				end
			end
			if (cfg_we)
				width_reg = cfg_wdata;
			errors  <= errors + bad;
			pending <= expected_sums.size();
		end
	end

endmodule

>>> test/tb_color_backproject_integral_image.sv
module tb_color_backproject_integral_image;
	import cbii_pkg::*;

	// Hard stop for a hung run, far above the slowest legal run with every gap
	// and every stall at its longest.
	localparam int RUN_LIMIT     = 1_000_000;
	// Least number of requests in the randomized phases; the last may run past it.
	localparam int RANDOM_TARGET = 550;
	localparam int WIDTH_ALL_ONES = (1 << LINE_WIDTH_BITS) - 1;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	in_item_t                   in_item;
	logic                       res_valid;
	logic                       res_stall;
	out_item_t                  res_item;
	logic                       cfg_we;
	logic [LINE_WIDTH_BITS-1:0] cfg_wdata;

	int errors;
	int pending;
	int cycle_count = 0;

	// The effective row width last programmed. Whenever it grows, the line
	// store holds no previous row for the new columns, so the next pixel must
	// open a new frame; need_frame carries that obligation until it is met.
	int unsigned active_width;
	bit          need_frame;
	// During a quiet stretch the sender never leaves a gap between requests.
	bit          quiet;

	color_backproject_integral_image u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	cbii_integral_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side back-pressure. Free and stalled stretches alternate; most of
	// them are short, and now and then a long free stretch or a
	// long stall lets the pipeline run flat out or fill up completely.
	initial begin : result_backpressure
		int unsigned run_len;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
			res_stall <= 1'b0;
			repeat (run_len) @(negedge clk);
			run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			res_stall <= 1'b1;
			repeat (run_len) @(negedge clk);
		end
	end

	// Presents one request and holds it until the block takes it. An optional
	// gap with valid low comes first; valid is otherwise left high so that
	// back-to-back requests flow without a bubble. Every call starts and ends
	// at a falling edge.
	task automatic push_request(input in_item_t req);
		int unsigned roll;
		int unsigned gap;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 50)
			gap = 0;
		else if (roll < 93)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= req;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// A pixel request. The table fields are ignored by the block, so they
	// carry random bits. A pending frame obligation forces the frame mark.
	task automatic send_pixel(
		input logic [CHAN_BITS-1:0] c0,
		input logic [CHAN_BITS-1:0] c1,
		input logic [CHAN_BITS-1:0] c2,
		input bit                   fresh
	);
		in_item_t req;
		req.func        = FUNC_PIXEL;
		req.frame_start = fresh | need_frame;
		req.chan0       = c0;
		req.chan1       = c1;
		req.chan2       = c2;
		req.table_index = BIN_BITS'($urandom);
		req.table_value = TABLE_VAL_BITS'($urandom);
		need_frame = 1'b0;
		push_request(req);
	endtask

	// A table write request. The frame mark and the channels are ignored, so
	// they carry random bits as well.
	task automatic send_table_write(
		input logic [BIN_BITS-1:0]              slot,
		input logic signed [TABLE_VAL_BITS-1:0] weight
	);
		in_item_t req;
		req.func        = FUNC_TABLE;
		req.frame_start = 1'($urandom);
		req.chan0       = CHAN_BITS'($urandom);
		req.chan1       = CHAN_BITS'($urandom);
		req.chan2       = CHAN_BITS'($urandom);
		req.table_index = slot;
		req.table_value = weight;
		push_request(req);
	endtask

	// Drops valid and waits until every predicted result has come back, then
	// waits out a tail so that table writes, which give no result,
	// have also left the pipeline.
	task automatic settle(input int tail);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	// Programs the row width once the block is idle. The row position is left
	// where it is, so narrowing in mid-row exercises the early end of a row.
	task automatic load_width(input logic [LINE_WIDTH_BITS-1:0] value);
		int unsigned span;
		if (value == 0)
			span = 1;
		else if (value > MAX_LINE_DEFAULT)
			span = MAX_LINE_DEFAULT;
		else
			span = 32'(value);
		settle(8);
		if (span > active_width)
			need_frame = 1'b1;
		active_width = span;
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned phase_len;
		int unsigned roll;
		int unsigned width_pick;
		int          slot;
		in_valid     = 1'b0;
		in_item      = '0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		arst_n       = 1'b0;
		need_frame   = 1'b0;
		quiet        = 1'b0;
		active_width = 32'(LINE_WIDTH_RESET);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every table word is written before any pixel can look it up, since
		// the table powers up with unknown contents.
		for (slot = 0; slot < TABLE_DEPTH; slot++) begin
			if (slot % 64 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			send_table_write(BIN_BITS'(slot), TABLE_VAL_BITS'($urandom));
		end
		quiet = 1'b0;

		// Directed part. Bins at both ends of the table get the most negative
		// and most positive weights, and three more bins get zero, one and
		// minus one so that the mask decision is seen on both sides of zero.
		send_table_write(9'h000, 16'sh8000);
		send_table_write(9'h1FF, 16'sh7FFF);
		send_table_write(9'h049, 16'sh0000);
		send_table_write(9'h092, 16'sh0001);
		send_table_write(9'h124, -16'sh0001);

		// First row at the reset width: each channel at its extremes, on its
		// own, and just either side of a bin boundary.
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd32, 8'd32, 8'd32, 1'b0);
		send_pixel(8'd64, 8'd95, 8'd64, 1'b0);
		send_pixel(8'd159, 8'd128, 8'd159, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(8'd31, 8'd31, 8'd31, 1'b0);

		// A width of zero acts as one. The row position is already past it, so
		// the next pixel closes the row; after that every pixel is a row of its
		// own and the sums pile up down the single column.
		load_width('0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd224, 8'd224, 8'd224, 1'b0);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

		// A table word rewritten right before the pixel that reads it.
		send_table_write(9'h000, 16'sh0064);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);

		// All ones in the width register acts as the line store size.
		load_width(LINE_WIDTH_BITS'(WIDTH_ALL_ONES));
		send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
		send_pixel(8'd50, 8'd100, 8'd200, 1'b0);

		load_width(11'd1);
		send_pixel(8'd96, 8'd160, 8'd224, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);

		// Random phases, each with its own row width. Narrow rows dominate so
		// that many rows wrap and read the line store; a few phases use widths
		// at or above the line store size. About one request in ten rewrites a
		// table word, and a frame mark turns up now and then on its own.
		sent = 0;
		while (sent < RANDOM_TARGET) begin
			roll = $urandom_range(0, 19);
			if (roll == 0)
				width_pick = 0;
			else if (roll < 14)
				width_pick = $urandom_range(1, 12);
			else if (roll < 19)
				width_pick = $urandom_range(13, 64);
			else if ($urandom_range(0, 1) == 0)
				width_pick = MAX_LINE_DEFAULT;
			else
				width_pick = $urandom_range(MAX_LINE_DEFAULT + 1, WIDTH_ALL_ONES);
			load_width(LINE_WIDTH_BITS'(width_pick));
			quiet = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(8, 60);
			repeat (phase_len) begin
				if ($urandom_range(0, 9) == 0)
					send_table_write(BIN_BITS'($urandom), TABLE_VAL_BITS'($urandom));
				else
					send_pixel(CHAN_BITS'($urandom), CHAN_BITS'($urandom),
						CHAN_BITS'($urandom), $urandom_range(0, 29) == 0);
			end
			sent += phase_len;
		end

		settle(64);
		if (pending != 0)
			$display("%0t: %0d expected results never arrived", $time, pending);
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
